// ===== sv/midi_stream_parser_assert.svh =====
// Assertion macros shared by the parser RTL.
`ifndef MIDI_STREAM_PARSER_ASSERT_SVH
`define MIDI_STREAM_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/msp_pkg.sv =====
`default_nettype none

package msp_pkg;

   // Status byte decoding.
   localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
   localparam logic [3:0] TYPE_PRESSURE = 4'hD;
   localparam logic [3:0] TYPE_SYSTEM   = 4'hF;
   localparam logic [7:0] COMMENT_STATUS = 8'hFF;

   // Result encodings.
   localparam logic       KIND_CHANNEL = 1'b0;
   localparam logic       KIND_TEXT    = 1'b1;
   localparam logic [1:0] LEN_SHORT    = 2'd2;
   localparam logic [1:0] LEN_LONG     = 2'd3;

endpackage

`default_nettype wire

// ===== sv/midi_stream_parser.sv =====
// MIDI serial byte-stream parser.
//
// Requests arrive on the req_ channel, one received byte (req_rx_byte) each,
// with req_valid/req_stall handshaking. Finished channel messages (types 0x8
// through 0xE, running status kept) and comment text bytes leave on the rsp_
// channel; rsp_kind tells them apart. The message FF 00 00 opens a comment
// whose next byte is its length; that many text bytes follow, the final one
// flagged by rsp_text_last. Bytes that finish nothing produce no response.
//
// Responses are registered: a byte's response is shown by the output
// register in the cycle after it is taken. One byte is accepted every cycle
// while the output register is empty or being drained in the same cycle.
// When the receiver holds rsp_stall with a response pending, req_stall is
// raised and the pending response and parser state hold until it is taken.
//
// Synchronous reset clears the parser: it waits for a status byte, running
// status is zero, no comment is open and no response is pending.
`default_nettype none

`include "midi_stream_parser_assert.svh"

module midi_stream_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_kind,
   output logic [7:0]      rsp_status_byte,
   output logic [6:0]      rsp_first_data,
   output logic [6:0]      rsp_second_data,
   output logic [1:0]      rsp_msg_length,
   output logic [7:0]      rsp_text_byte,
   output logic            rsp_text_last
);

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_LENGTH,
      PHASE_TEXT
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       synced_ff, synced_in;
   logic [7:0] status_ff, status_in;
   logic       want_ff, want_in;
   logic [6:0] held_ff, held_in;
   logic [7:0] remain_ff, remain_in;

   logic       rsp_valid_ff;
   logic       kind_ff, kind_in;
   logic [7:0] status_out_ff, status_out_in;
   logic [6:0] first_ff, first_in;
   logic [6:0] second_ff, second_in;
   logic [1:0] length_ff, length_in;
   logic [7:0] text_ff, text_in;
   logic       last_ff, last_in;

   logic       emit;
   logic       accept;
   logic [7:0] remain_dec;
   logic       finish;
   logic       finish_two;
   logic [6:0] fin_d1;
   logic [6:0] fin_d2;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign remain_dec = remain_ff - 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      synced_in     = synced_ff;
      status_in     = status_ff;
      want_in       = want_ff;
      held_in       = held_ff;
      remain_in     = remain_ff;
      emit          = 1'b0;
      finish        = 1'b0;
      finish_two    = 1'b0;
      fin_d1        = req_rx_byte[6:0];
      fin_d2        = 7'd0;
      kind_in       = msp_pkg::KIND_CHANNEL;
      status_out_in = status_ff;
      first_in      = 7'd0;
      second_in     = 7'd0;
      length_in     = msp_pkg::LEN_SHORT;
      text_in       = 8'd0;
      last_in       = 1'b0;

      unique case (phase_ff)
         PHASE_LENGTH: begin
            // The length byte also replaces the running status.
            status_in = req_rx_byte;
            remain_in = req_rx_byte;
            want_in   = 1'b0;
            phase_in  = (req_rx_byte != 8'd0) ? PHASE_TEXT : PHASE_IDLE;
         end
         PHASE_TEXT: begin
            remain_in     = remain_dec;
            emit          = 1'b1;
            kind_in       = msp_pkg::KIND_TEXT;
            status_out_in = 8'd0;
            length_in     = 2'd0;
            text_in       = req_rx_byte;
            last_in       = (remain_dec == 8'd0);
            if (remain_dec == 8'd0) begin
               phase_in = PHASE_IDLE;
            end
         end
         default: begin
            phase_in = PHASE_IDLE;
            if (req_rx_byte[7]) begin
               synced_in = 1'b1;
               status_in = req_rx_byte;
               want_in   = 1'b0;
            end else if (synced_ff) begin
               if (want_ff) begin
                  want_in    = 1'b0;
                  finish     = 1'b1;
                  finish_two = 1'b1;
                  fin_d1     = held_ff;
                  fin_d2     = req_rx_byte[6:0];
               end else if (status_ff[7:4] == msp_pkg::TYPE_PROGRAM ||
                            status_ff[7:4] == msp_pkg::TYPE_PRESSURE) begin
                  finish = 1'b1;
               end else begin
                  held_in = req_rx_byte[6:0];
                  want_in = 1'b1;
               end
            end
         end
      endcase

      if (finish) begin
         first_in  = fin_d1;
         second_in = fin_d2;
         length_in = finish_two ? msp_pkg::LEN_LONG : msp_pkg::LEN_SHORT;
         if (finish_two && status_ff == msp_pkg::COMMENT_STATUS &&
             fin_d1 == 7'd0 && fin_d2 == 7'd0) begin
            phase_in = PHASE_LENGTH;
         end else if (status_ff[7] && status_ff[7:4] != msp_pkg::TYPE_SYSTEM) begin
            emit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         synced_ff    <= 1'b0;
         status_ff    <= 8'd0;
         want_ff      <= 1'b0;
         held_ff      <= 7'd0;
         remain_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            synced_ff    <= synced_in;
            status_ff    <= status_in;
            want_ff      <= want_in;
            held_ff      <= held_in;
            remain_ff    <= remain_in;
            rsp_valid_ff <= emit;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept && emit) begin
         kind_ff       <= kind_in;
         status_out_ff <= status_out_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         length_ff     <= length_in;
         text_ff       <= text_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_status_byte = status_out_ff;
   assign rsp_first_data  = first_ff;
   assign rsp_second_data = second_ff;
   assign rsp_msg_length  = length_ff;
   assign rsp_text_byte   = text_ff;
   assign rsp_text_last   = last_ff;

   `MSP_ASSERT_NEXT(a_text_emits, clock, reset, accept && phase_ff == PHASE_TEXT, rsp_valid_ff && kind_ff == msp_pkg::KIND_TEXT, "text request did not produce a text response")
   `MSP_ASSERT_NOW(a_text_count, clock, reset, phase_ff == PHASE_TEXT, remain_ff != 8'd0, "text phase with no bytes remaining")
   `MSP_ASSERT_NOW(a_msg_length, clock, reset, rsp_valid_ff && kind_ff == msp_pkg::KIND_CHANNEL, length_ff == msp_pkg::LEN_SHORT || length_ff == msp_pkg::LEN_LONG, "channel message with bad length")
   `MSP_ASSERT_NOW(a_text_open, clock, reset, rsp_valid_ff && kind_ff == msp_pkg::KIND_TEXT && !last_ff, phase_ff == PHASE_TEXT, "comment closed before its last text byte")

endmodule

`default_nettype wire

// ===== sim/tb_midi_stream_parser.sv =====
`default_nettype none

module tb_midi_stream_parser;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_BYTES = 1500;
   localparam int unsigned TABLE_ROWS   = 28;

   typedef enum logic [1:0] {
      PHASE_NONE   = 2'd0,
      PHASE_LENGTH = 2'd1,
      PHASE_TEXT   = 2'd2
   } comment_phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] status_byte;
      logic [6:0] first_data;
      logic [6:0] second_data;
      logic [1:0] msg_length;
      logic [7:0] text_byte;
      logic       text_last;
   } midi_result_type;

   typedef struct packed {
      logic [7:0]      rx;
      logic            pinned;
      logic            has_rsp;
      midi_result_type rsp;
   } stim_row_type;

   localparam midi_result_type NO_RSP = '0;

   // Rows with pinned set carry a hand-written expectation; the others are predicted.
   localparam stim_row_type DIRECTED_ROWS [TABLE_ROWS] = '{
      '{8'h7F, 1'b1, 1'b0, NO_RSP},
      '{8'h90, 1'b1, 1'b0, NO_RSP},
      '{8'h3C, 1'b1, 1'b0, NO_RSP},
      '{8'h7F, 1'b1, 1'b1, '{msp_pkg::KIND_CHANNEL, 8'h90, 7'h3C, 7'h7F,
                             msp_pkg::LEN_LONG, 8'h00, 1'b0}},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b1, '{msp_pkg::KIND_CHANNEL, 8'h90, 7'h00, 7'h00,
                             msp_pkg::LEN_LONG, 8'h00, 1'b0}},
      '{8'hC5, 1'b1, 1'b0, NO_RSP},
      '{8'h7F, 1'b1, 1'b1, '{msp_pkg::KIND_CHANNEL, 8'hC5, 7'h7F, 7'h00,
                             msp_pkg::LEN_SHORT, 8'h00, 1'b0}},
      '{8'hDF, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b1, '{msp_pkg::KIND_CHANNEL, 8'hDF, 7'h00, 7'h00,
                             msp_pkg::LEN_SHORT, 8'h00, 1'b0}},
      '{8'hF3, 1'b1, 1'b0, NO_RSP},
      '{8'h10, 1'b1, 1'b0, NO_RSP},
      '{8'h20, 1'b1, 1'b0, NO_RSP},
      '{8'hFF, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h02, 1'b1, 1'b0, NO_RSP},
      '{8'hFF, 1'b1, 1'b1, '{msp_pkg::KIND_TEXT, 8'h00, 7'h00, 7'h00, 2'd0, 8'hFF, 1'b0}},
      '{8'h80, 1'b1, 1'b1, '{msp_pkg::KIND_TEXT, 8'h00, 7'h00, 7'h00, 2'd0, 8'h80, 1'b1}},
      '{8'h11, 1'b1, 1'b0, NO_RSP},
      '{8'h22, 1'b1, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'hA3, 1'b0, 1'b0, NO_RSP},
      '{8'h01, 1'b0, 1'b0, NO_RSP},
      '{8'h7E, 1'b0, 1'b0, NO_RSP}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_status_byte;
   logic [6:0] rsp_first_data;
   logic [6:0] rsp_second_data;
   logic [1:0] rsp_msg_length;
   logic [7:0] rsp_text_byte;
   logic       rsp_text_last;

   midi_stream_parser u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_status_byte (rsp_status_byte),
      .rsp_first_data  (rsp_first_data),
      .rsp_second_data (rsp_second_data),
      .rsp_msg_length  (rsp_msg_length),
      .rsp_text_byte   (rsp_text_byte),
      .rsp_text_last   (rsp_text_last)
   );

   always #5 clock = ~clock;

   // Parser model state.
   logic              seen_status = 1'b0;
   logic [7:0]        running_status = 8'h00;
   logic              await_second = 1'b0;
   logic [6:0]        first_held = 7'h00;
   comment_phase_type comment_state = PHASE_NONE;
   logic [7:0]        text_left = 8'h00;

   midi_result_type   expected_msgs [$];
   int unsigned       mismatches = 0;
   int unsigned       cycle_count = 0;
   int unsigned       bytes_sent = 0;
   logic              quiet = 1'b0;

   // The directed loop uses these to pin the expectation of the byte being presented.
   logic              pin_valid = 1'b0;
   logic              pin_has = 1'b0;
   midi_result_type   pin_rsp = '0;

   function automatic logic finish_message(input logic [6:0] d1, input logic [6:0] d2,
                                           input logic two_data,
                                           output midi_result_type r);
      r = '0;
      if (running_status == msp_pkg::COMMENT_STATUS && d1 == 7'h00 && d2 == 7'h00 &&
          two_data) begin
         comment_state = PHASE_LENGTH;
         return 1'b0;
      end
      if (!running_status[7] || running_status[7:4] == msp_pkg::TYPE_SYSTEM) return 1'b0;
      r.kind        = msp_pkg::KIND_CHANNEL;
      r.status_byte = running_status;
      r.first_data  = d1;
      r.second_data = two_data ? d2 : 7'h00;
      r.msg_length  = two_data ? msp_pkg::LEN_LONG : msp_pkg::LEN_SHORT;
      return 1'b1;
   endfunction

   function automatic logic parse_byte(input logic [7:0] b, output midi_result_type r);
      r = '0;
      if (comment_state == PHASE_LENGTH) begin
         running_status = b;
         text_left      = b;
         await_second   = 1'b0;
         comment_state  = (b != 8'h00) ? PHASE_TEXT : PHASE_NONE;
         return 1'b0;
      end
      if (comment_state == PHASE_TEXT) begin
         text_left   = text_left - 8'd1;
         r.kind      = msp_pkg::KIND_TEXT;
         r.text_byte = b;
         r.text_last = (text_left == 8'h00);
         if (r.text_last) comment_state = PHASE_NONE;
         return 1'b1;
      end
      comment_state = PHASE_NONE;
      if (b[7]) begin
         seen_status    = 1'b1;
         running_status = b;
         await_second   = 1'b0;
         return 1'b0;
      end
      if (!seen_status) return 1'b0;
      if (await_second) begin
         await_second = 1'b0;
         return finish_message(first_held, b[6:0], 1'b1, r);
      end
      if (running_status[7:4] == msp_pkg::TYPE_PROGRAM ||
          running_status[7:4] == msp_pkg::TYPE_PRESSURE)
         return finish_message(b[6:0], 7'h00, 1'b0, r);
      first_held   = b[6:0];
      await_second = 1'b1;
      return 1'b0;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatches++;
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
   endtask

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 23);
   end

   // Results are checked before the request at the same edge is predicted;
   // results are registered, so a result never belongs to the request beside it.
   always @(posedge clock) begin : monitor
      midi_result_type want;
      midi_result_type predicted;
      logic            made;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_msgs.size() == 0) begin
               mismatches++;
               $error("unexpected result: kind 0x%0h status 0x%0h text 0x%0h",
                      rsp_kind, rsp_status_byte, rsp_text_byte);
            end else begin
               want = expected_msgs.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("status_byte", want.status_byte, rsp_status_byte);
               check_field("first_data", want.first_data, rsp_first_data);
               check_field("second_data", want.second_data, rsp_second_data);
               check_field("msg_length", want.msg_length, rsp_msg_length);
               check_field("text_byte", want.text_byte, rsp_text_byte);
               check_field("text_last", want.text_last, rsp_text_last);
            end
         end
         if (req_valid && !req_stall) begin
            made = parse_byte(req_rx_byte, predicted);
            if (pin_valid) begin
               if (pin_has) expected_msgs.push_back(pin_rsp);
            end else if (made) begin
               expected_msgs.push_back(predicted);
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_byte(input logic [7:0] b);
      if (!quiet && $urandom_range(99) < 15) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic wait_for_results();
      req_valid = 1'b0;
      while (expected_msgs.size() != 0) @(negedge clock);
   endtask

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int unsigned pick;
      int unsigned reps;
      int unsigned text_len;
      logic [7:0]  st;
      logic        drained;
      drained = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < TABLE_ROWS; i++) begin
         pin_valid = DIRECTED_ROWS[i].pinned;
         pin_has   = DIRECTED_ROWS[i].has_rsp;
         pin_rsp   = DIRECTED_ROWS[i].rsp;
         send_byte(DIRECTED_ROWS[i].rx);
      end
      pin_valid = 1'b0;

      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         quiet = (bytes_sent >= 500 && bytes_sent < 800);
         if (!drained && bytes_sent >= 1100) begin
            wait_for_results();
            drained = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 60) begin
            // Channel status byte, then one to three messages, the later ones under running status.
            st = 8'($urandom_range(8'h80, 8'hEF));
            send_byte(st);
            reps = $urandom_range(1, 3);
            repeat (reps) begin
               send_byte(8'($urandom_range(0, 127)));
               if (st[7:4] != msp_pkg::TYPE_PROGRAM && st[7:4] != msp_pkg::TYPE_PRESSURE)
                  send_byte(8'($urandom_range(0, 127)));
            end
         end else if (pick < 70) begin
            send_byte(msp_pkg::COMMENT_STATUS);
            send_byte(8'h00);
            send_byte(8'h00);
            text_len = ($urandom_range(49) == 0) ? $urandom_range(100, 255)
                                                 : $urandom_range(0, 6);
            send_byte(8'(text_len));
            repeat (text_len) send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 78) begin
            send_byte(8'($urandom_range(8'hF0, 8'hFF)));
            reps = $urandom_range(0, 3);
            repeat (reps) send_byte(8'($urandom_range(0, 127)));
         end else if (pick < 85) begin
            // A comment opener FF 00 and a random byte, which cuts it short unless it is 00.
            send_byte(msp_pkg::COMMENT_STATUS);
            send_byte(8'h00);
            send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end
      quiet = 1'b0;

      wait_for_results();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && expected_msgs.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
